FILE: rtl/pcwe_pkg.sv
package pcwe_pkg;

    // fixed field widths of the bar and level channels and the configuration port
    localparam int FIELD_W    = 32;
    localparam int WIN_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // register reset values
    localparam logic             SHORT_MODE_RST = 1'b0;
    localparam logic [WIN_W-1:0] ENTRY_WIN_RST  = 7'd20;
    localparam logic [WIN_W-1:0] TRAIL_WIN_RST  = 7'd10;
    localparam logic [WIN_W-1:0] STOP_WIN_RST   = 7'd20;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_MODE = 2'd0,
        CFG_ENTRY_WIN  = 2'd1,
        CFG_TRAIL_WIN  = 2'd2,
        CFG_STOP_WIN   = 2'd3
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_DONE
    } t_state;

    // what every history cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_ROTATE
    } t_cell_op;

    // control of one extreme accumulator
    typedef struct packed {
        logic take;
        logic first;
        logic want_max;
    } t_acc_ctl;

endpackage

FILE: rtl/pcwe_bar_if.sv
interface pcwe_bar_if import pcwe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] low_price;
    logic [FIELD_W-1:0] high_price;
    logic               last_bar;

    modport source (output valid, low_price, high_price, last_bar, input ready);
    modport sink   (input valid, low_price, high_price, last_bar, output ready);
endinterface

FILE: rtl/pcwe_lvl_if.sv
interface pcwe_lvl_if import pcwe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] entry_level;
    logic               entry_valid;
    logic [FIELD_W-1:0] trail_level;
    logic               trail_valid;
    logic [FIELD_W-1:0] stop_level;
    logic               stop_valid;

    modport source (output valid, entry_level, entry_valid, trail_level, trail_valid,
                    stop_level, stop_valid, input ready);
    modport sink   (input valid, entry_level, entry_valid, trail_level, trail_valid,
                    stop_level, stop_valid, output ready);
endinterface

FILE: rtl/pcwe_cell.sv
module pcwe_cell import pcwe_pkg::*; #(
    parameter int PRICE_BITS = 32
) (
    input  logic                  i_clk,
    input  t_cell_op              i_op,
    input  logic [PRICE_BITS-1:0] i_prev_low,
    input  logic [PRICE_BITS-1:0] i_prev_high,
    input  logic [PRICE_BITS-1:0] i_next_low,
    input  logic [PRICE_BITS-1:0] i_next_high,
    output logic [PRICE_BITS-1:0] o_low,
    output logic [PRICE_BITS-1:0] o_high
);

    logic [PRICE_BITS-1:0] r_low;
    logic [PRICE_BITS-1:0] r_high;
    logic [PRICE_BITS-1:0] n_low;
    logic [PRICE_BITS-1:0] n_high;

    // push takes the newer neighbor's bar, rotate takes the older one
    always_comb begin
        case (i_op)
            CELL_PUSH: begin
                n_low  = i_prev_low;
                n_high = i_prev_high;
            end
            CELL_ROTATE: begin
                n_low  = i_next_low;
                n_high = i_next_high;
            end
            default: begin
                n_low  = r_low;
                n_high = r_high;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_low  <= n_low;
        r_high <= n_high;
    end

    assign o_low  = r_low;
    assign o_high = r_high;

endmodule

FILE: rtl/pcwe_acc.sv
module pcwe_acc import pcwe_pkg::*; #(
    parameter int PRICE_BITS = 32
) (
    input  logic                  i_clk,
    input  t_acc_ctl              i_ctl,
    input  logic [PRICE_BITS-1:0] i_data,
    output logic [PRICE_BITS-1:0] o_best
);

    logic [PRICE_BITS-1:0] r_best;
    logic                  w_better;

    // strict compare keeps the first seen value on ties
    assign w_better = i_ctl.want_max ? (i_data > r_best) : (i_data < r_best);

    always_ff @(posedge i_clk) begin
        if (i_ctl.take && (i_ctl.first || w_better)) begin
            r_best <= i_data;
        end
    end

    assign o_best = r_best;

endmodule

FILE: rtl/price_channel_window_extremes.sv
// channel  dir  handshake      payload
// i_bar    in   valid/ready    low_price, high_price, last_bar
// o_lvl    out  valid/ready    entry/trail/stop level and valid
// i_cfg    in   write enable   i_cfg_idx, i_cfg_wdata
//
// one bar is pushed into the history ring, then the whole ring is rotated
// past the single compare point at its head, and then the result register
// is loaded.
// reset is synchronous and active low; it clears control, the bar count, the
// configuration registers and the output valid. the history itself needs no clearing.
// a stalled result holds the block in its final state until the transfer.
module price_channel_window_extremes import pcwe_pkg::*; #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    pcwe_bar_if.sink              i_bar,
    pcwe_lvl_if.source            o_lvl
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    // window register clamped into 1 .. MAX_WINDOW
    function automatic logic [CNT_W-1:0] clamp_win(input logic [WIN_W-1:0] w);
        logic [CMP_W-1:0] wz;
        wz = CMP_W'(w);
        if (wz == '0) begin
            return CNT_W'(1);
        end else if (wz > CMP_W'(MAX_WINDOW)) begin
            return CNT_W'(MAX_WINDOW);
        end else begin
            return CNT_W'(wz);
        end
    endfunction

    // configuration registers
    logic             r_short_mode;
    logic [WIN_W-1:0] r_entry_win;
    logic [WIN_W-1:0] r_trail_win;
    logic [WIN_W-1:0] r_stop_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_mode <= SHORT_MODE_RST;
            r_entry_win  <= ENTRY_WIN_RST;
            r_trail_win  <= TRAIL_WIN_RST;
            r_stop_win   <= STOP_WIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SHORT_MODE: r_short_mode <= i_cfg_wdata[0];
                CFG_ENTRY_WIN:  r_entry_win  <= i_cfg_wdata[WIN_W-1:0];
                CFG_TRAIL_WIN:  r_trail_win  <= i_cfg_wdata[WIN_W-1:0];
                CFG_STOP_WIN:   r_stop_win   <= i_cfg_wdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [CNT_W-1:0] w_entry_w;
    logic [CNT_W-1:0] w_trail_w;
    logic [CNT_W-1:0] w_stop_w;

    assign w_entry_w = clamp_win(r_entry_win);
    assign w_trail_w = clamp_win(r_trail_win);
    assign w_stop_w  = clamp_win(r_stop_win);

    // sequencer registers
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_seen;
    logic             r_last;
    logic             w_sweep_end;
    logic             w_accept;
    logic             w_load;
    logic             w_out_free;
    t_cell_op         w_op;

    assign w_out_free  = !o_lvl.valid || o_lvl.ready;
    assign w_sweep_end = (r_idx == IDX_W'(MAX_WINDOW - 1));
    assign w_accept    = i_bar.valid && i_bar.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_bar.valid) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_bar.ready = 1'b0;
        w_op        = CELL_HOLD;
        w_load      = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_bar.ready = 1'b1;
                if (i_bar.valid) begin
                    w_op = CELL_PUSH;
                end
            end
            S_SWEEP: w_op = CELL_ROTATE;
            S_DONE:  w_load = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_seen  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_SWEEP) begin
                r_idx <= w_sweep_end ? '0 : r_idx + IDX_W'(1);
            end
            if (w_accept) begin
                r_last <= i_bar.last_bar;
                if (r_seen != CNT_W'(MAX_WINDOW)) begin
                    r_seen <= r_seen + CNT_W'(1);
                end
            end
            // series ends once its last result is loaded
            if (w_load && r_last) begin
                r_seen <= '0;
            end
        end
    end

    // history ring, cell 0 holds the newest bar between sweeps
    logic [PRICE_BITS-1:0] w_low  [MAX_WINDOW];
    logic [PRICE_BITS-1:0] w_high [MAX_WINDOW];
    logic [PRICE_BITS-1:0] w_new_low;
    logic [PRICE_BITS-1:0] w_new_high;

    assign w_new_low  = PRICE_BITS'(i_bar.low_price);
    assign w_new_high = PRICE_BITS'(i_bar.high_price);

    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
        pcwe_cell #(
            .PRICE_BITS (PRICE_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_prev_low  ((k == 0) ? w_new_low  : w_low[(k + MAX_WINDOW - 1) % MAX_WINDOW]),
            .i_prev_high ((k == 0) ? w_new_high : w_high[(k + MAX_WINDOW - 1) % MAX_WINDOW]),
            .i_next_low  (w_low[(k + 1) % MAX_WINDOW]),
            .i_next_high (w_high[(k + 1) % MAX_WINDOW]),
            .o_low       (w_low[k]),
            .o_high      (w_high[k])
        );
    end

    // compare point at the ring head, entry r_idx passes by in sweep cycle r_idx
    t_acc_ctl              w_entry_ctl;
    t_acc_ctl              w_trail_ctl;
    t_acc_ctl              w_stop_ctl;
    logic [CNT_W-1:0]      w_pos;
    logic                  w_sweeping;
    logic [PRICE_BITS-1:0] w_entry_data;
    logic [PRICE_BITS-1:0] w_stop_data;
    logic [PRICE_BITS-1:0] w_entry_best;
    logic [PRICE_BITS-1:0] w_trail_best;
    logic [PRICE_BITS-1:0] w_stop_best;

    assign w_pos      = CNT_W'(r_idx);
    assign w_sweeping = (r_state == S_SWEEP);

    // long: entry is max of highs, stops are min of lows; short swaps both
    assign w_entry_data = r_short_mode ? w_low[0] : w_high[0];
    assign w_stop_data  = r_short_mode ? w_high[0] : w_low[0];

    assign w_entry_ctl = '{take: w_sweeping && (w_pos < w_entry_w),
                           first: (r_idx == '0), want_max: !r_short_mode};
    assign w_trail_ctl = '{take: w_sweeping && (w_pos < w_trail_w),
                           first: (r_idx == '0), want_max: r_short_mode};
    assign w_stop_ctl  = '{take: w_sweeping && (w_pos < w_stop_w),
                           first: (r_idx == '0), want_max: r_short_mode};

    pcwe_acc #(.PRICE_BITS(PRICE_BITS)) u_entry_acc (
        .i_clk  (i_clk),
        .i_ctl  (w_entry_ctl),
        .i_data (w_entry_data),
        .o_best (w_entry_best)
    );

    pcwe_acc #(.PRICE_BITS(PRICE_BITS)) u_trail_acc (
        .i_clk  (i_clk),
        .i_ctl  (w_trail_ctl),
        .i_data (w_stop_data),
        .o_best (w_trail_best)
    );

    pcwe_acc #(.PRICE_BITS(PRICE_BITS)) u_stop_acc (
        .i_clk  (i_clk),
        .i_ctl  (w_stop_ctl),
        .i_data (w_stop_data),
        .o_best (w_stop_best)
    );

    // result register
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_entry_level;
    logic [FIELD_W-1:0] r_trail_level;
    logic [FIELD_W-1:0] r_stop_level;
    logic               r_entry_ok;
    logic               r_trail_ok;
    logic               r_stop_ok;
    logic               w_entry_ok;
    logic               w_trail_ok;
    logic               w_stop_ok;

    assign w_entry_ok = (r_seen >= w_entry_w);
    assign w_trail_ok = (r_seen >= w_trail_w);
    assign w_stop_ok  = (r_seen >= w_stop_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_lvl.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // an unfilled window reads as level zero
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry_level <= w_entry_ok ? FIELD_W'(w_entry_best) : '0;
            r_trail_level <= w_trail_ok ? FIELD_W'(w_trail_best) : '0;
            r_stop_level  <= w_stop_ok  ? FIELD_W'(w_stop_best)  : '0;
            r_entry_ok    <= w_entry_ok;
            r_trail_ok    <= w_trail_ok;
            r_stop_ok     <= w_stop_ok;
        end
    end

    assign o_lvl.valid       = r_out_valid;
    assign o_lvl.entry_level = r_entry_level;
    assign o_lvl.entry_valid = r_entry_ok;
    assign o_lvl.trail_level = r_trail_level;
    assign o_lvl.trail_valid = r_trail_ok;
    assign o_lvl.stop_level  = r_stop_level;
    assign o_lvl.stop_valid  = r_stop_ok;

endmodule

FILE: tb/price_channel_window_extremes_test.sv
module price_channel_window_extremes_test import pcwe_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_DEPTH     = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 6;
    localparam int BARS_PER_PHASE = 75;

    // one bar and one set of channel levels, as carried on the channels
    typedef struct packed {
        logic [FIELD_W-1:0] low_price;
        logic [FIELD_W-1:0] high_price;
        logic               last_bar;
    } t_bar;

    typedef struct packed {
        logic [FIELD_W-1:0] entry_level;
        logic               entry_valid;
        logic [FIELD_W-1:0] trail_level;
        logic               trail_valid;
        logic [FIELD_W-1:0] stop_level;
        logic               stop_valid;
    } t_lvl;

    typedef enum logic [1:0] {
        ROW_BAR,
        ROW_BAR_TYPED,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        t_cfg_idx             idx;
        logic [CFG_DATA_W-1:0] data;
        t_bar                 bar;
        t_lvl                 lvl;
    } t_dir_row;

    localparam t_bar BAR_NONE = '0;
    localparam t_lvl LVL_NONE = '0;
    // window of one: levels come straight from the current bar
    localparam t_lvl LVL_W1_MID   = '{32'h9ABC_DEF0, 1'b1, 32'h1234_5678, 1'b1,
                                      32'h1234_5678, 1'b1};
    localparam t_lvl LVL_W1_SPLIT = '{32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 1'b1,
                                      32'hFFFF_FFFF, 1'b1};

    // directed stimulus: reset windows, window zero, short mode, oversized windows
    t_dir_row directed_rows [24] = '{
        '{ROW_BAR_TYPED, CFG_SHORT_MODE, 7'd0, '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0}, LVL_NONE},
        '{ROW_BAR_TYPED, CFG_SHORT_MODE, 7'd0, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0001_8000, 32'h0002_0000, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h8000_0000, 32'hFFFF_FFFE, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0000_0001, 32'h0000_0001, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0000_FFFF, 32'hFFFF_0000, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0010_0000, 32'h0011_0000, 1'b1}, LVL_NONE},
        '{ROW_CFG, CFG_ENTRY_WIN, 7'd0, BAR_NONE, LVL_NONE},
        '{ROW_CFG, CFG_TRAIL_WIN, 7'd0, BAR_NONE, LVL_NONE},
        '{ROW_CFG, CFG_STOP_WIN, 7'd0, BAR_NONE, LVL_NONE},
        '{ROW_BAR_TYPED, CFG_SHORT_MODE, 7'd0, '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0},
          LVL_W1_MID},
        '{ROW_BAR_TYPED, CFG_SHORT_MODE, 7'd0, '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
          LVL_W1_SPLIT},
        '{ROW_CFG, CFG_SHORT_MODE, 7'h01, BAR_NONE, LVL_NONE},
        '{ROW_BAR_TYPED, CFG_SHORT_MODE, 7'd0, '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
          LVL_W1_SPLIT},
        '{ROW_CFG, CFG_ENTRY_WIN, 7'd127, BAR_NONE, LVL_NONE},
        '{ROW_CFG, CFG_TRAIL_WIN, 7'd64, BAR_NONE, LVL_NONE},
        '{ROW_CFG, CFG_STOP_WIN, 7'd2, BAR_NONE, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0003_0000, 32'h0004_0000, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0002_0000, 32'h0005_0000, 1'b0}, LVL_NONE},
        '{ROW_BAR, CFG_SHORT_MODE, 7'd0, '{32'h0001_0000, 32'h0006_0000, 1'b1}, LVL_NONE},
        '{ROW_CFG, CFG_SHORT_MODE, 7'h7E, BAR_NONE, LVL_NONE}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pcwe_bar_if bar_if ();
    pcwe_lvl_if lvl_if ();

    price_channel_window_extremes DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_bar       (bar_if),
        .o_lvl       (lvl_if)
    );

    // mirror of the block: registers, bar history and series length
    logic                  mode_short = SHORT_MODE_RST;
    logic [WIN_W-1:0]      win_entry  = ENTRY_WIN_RST;
    logic [WIN_W-1:0]      win_trail  = TRAIL_WIN_RST;
    logic [WIN_W-1:0]      win_stop   = STOP_WIN_RST;
    logic [FIELD_W-1:0]    low_hist  [HIST_DEPTH];
    logic [FIELD_W-1:0]    high_hist [HIST_DEPTH];
    int                    bars_in_series = 0;

    t_lvl                  pending_levels [$];
    int                    errors = 0;
    int                    idle_cycles = 0;
    int                    burst_left = 0;
    logic [FIELD_W-1:0]    walk_mid = 32'h0064_0000;
    int                    stall_kind = 0;
    int                    stretch_left = 0;
    int                    rx_cycle = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_window(input logic [WIN_W-1:0] w);
        if (w == 0) return 1;
        if (w > HIST_DEPTH) return HIST_DEPTH;
        return w;
    endfunction

    // max or min over the newest w bars of one history
    function automatic logic [FIELD_W-1:0] window_peak(input logic use_high,
                                                       input logic want_max,
                                                       input int w);
        logic [FIELD_W-1:0] best;
        logic [FIELD_W-1:0] v;
        best = use_high ? high_hist[0] : low_hist[0];
        for (int k = 1; k < w; k++) begin
            v = use_high ? high_hist[k] : low_hist[k];
            if (want_max ? (v > best) : (v < best)) best = v;
        end
        return best;
    endfunction

    // one channel: level is valid once its window is filled
    function automatic void channel_level(input logic [WIN_W-1:0] win, input logic use_high,
                                          input logic want_max,
                                          output logic [FIELD_W-1:0] level,
                                          output logic valid);
        int w;
        w = clamp_window(win);
        if (bars_in_series >= w) begin
            level = window_peak(use_high, want_max, w);
            valid = 1'b1;
        end else begin
            level = '0;
            valid = 1'b0;
        end
    endfunction

    // shift the bar in, compute the three levels, clear after a last bar
    function automatic t_lvl predict_levels(input t_bar b);
        t_lvl r;
        for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            low_hist[k]  = low_hist[k-1];
            high_hist[k] = high_hist[k-1];
        end
        low_hist[0]  = b.low_price;
        high_hist[0] = b.high_price;
        if (bars_in_series < HIST_DEPTH) bars_in_series++;
        channel_level(win_entry, !mode_short, !mode_short, r.entry_level, r.entry_valid);
        channel_level(win_trail, mode_short, mode_short, r.trail_level, r.trail_valid);
        channel_level(win_stop, mode_short, mode_short, r.stop_level, r.stop_valid);
        if (b.last_bar) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                low_hist[k]  = '0;
                high_hist[k] = '0;
            end
            bars_in_series = 0;
        end
        return r;
    endfunction

    // mostly a drifting price with a spread, sometimes fully random
    function automatic t_bar random_bar(input logic last);
        t_bar b;
        if ($urandom_range(0, 3) == 0) begin
            b.low_price  = $urandom;
            b.high_price = $urandom;
        end else begin
            walk_mid     = walk_mid + $urandom_range(0, 4096) - 32'd2048;
            b.low_price  = walk_mid - $urandom_range(0, 1024);
            b.high_price = walk_mid + $urandom_range(0, 1024);
        end
        b.last_bar = last;
        return b;
    endfunction

    // mostly legal windows, sometimes zero or above the history depth
    function automatic logic [WIN_W-1:0] pick_window();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
            1:       return 7'($urandom_range(1, 4));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] got,
                               input logic [FIELD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        case (idx)
            CFG_SHORT_MODE: mode_short = data[0];
            CFG_ENTRY_WIN:  win_entry  = data;
            CFG_TRAIL_WIN:  win_trail  = data;
            CFG_STOP_WIN:   win_stop   = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] mode, input logic [WIN_W-1:0] e,
                             input logic [WIN_W-1:0] t, input logic [WIN_W-1:0] s);
        write_reg(CFG_SHORT_MODE, mode);
        write_reg(CFG_ENTRY_WIN, e);
        write_reg(CFG_TRAIL_WIN, t);
        write_reg(CFG_STOP_WIN, s);
    endtask

    // drop valid and wait until every level has been taken
    task automatic settle();
        if (bar_if.valid === 1'b1) begin
            @(negedge i_clk);
            bar_if.valid = 1'b0;
        end
        while (pending_levels.size() != 0) @(negedge i_clk);
    endtask

    // present a bar, wait for its transfer, queue the expected levels, then pace
    task automatic feed_bar(input t_bar b, input logic use_typed, input t_lvl typed);
        t_lvl predicted;
        int   gap;
        @(negedge i_clk);
        bar_if.valid      = 1'b1;
        bar_if.low_price  = b.low_price;
        bar_if.high_price = b.high_price;
        bar_if.last_bar   = b.last_bar;
        @(posedge i_clk);
        while (bar_if.ready !== 1'b1) @(posedge i_clk);
        predicted = predict_levels(b);
        pending_levels.push_back(use_typed ? typed : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80)
                                              : $urandom_range(1, 3);
            @(negedge i_clk);
            bar_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // level receiver: stretches of always ready, random, patterned and stalled
    initial lvl_if.ready = 1'b0;

    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (stretch_left == 0) begin
            stall_kind   <= $urandom_range(0, 3);
            stretch_left <= $urandom_range(1, 60);
        end else begin
            stretch_left <= stretch_left - 1;
        end
        case (stall_kind)
            0:       lvl_if.ready <= 1'b1;
            1:       lvl_if.ready <= 1'($urandom_range(0, 1));
            2:       lvl_if.ready <= (rx_cycle % 5) != 0;
            default: lvl_if.ready <= 1'b0;
        endcase
    end

    // level checker and watchdog
    always @(posedge i_clk) begin
        t_lvl got;
        t_lvl want;
        if (i_rst_n) begin
            if ((bar_if.valid && bar_if.ready) || (lvl_if.valid && lvl_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (lvl_if.valid && lvl_if.ready) begin
                got = '{lvl_if.entry_level, lvl_if.entry_valid, lvl_if.trail_level,
                        lvl_if.trail_valid, lvl_if.stop_level, lvl_if.stop_valid};
                if (pending_levels.size() == 0) begin
                    report_mismatch("level transfer with nothing expected");
                end else begin
                    want = pending_levels.pop_front();
                    check_field("entry_level", got.entry_level, want.entry_level);
                    check_field("entry_valid", 32'(got.entry_valid), 32'(want.entry_valid));
                    check_field("trail_level", got.trail_level, want.trail_level);
                    check_field("trail_valid", 32'(got.trail_valid), 32'(want.trail_valid));
                    check_field("stop_level", got.stop_level, want.stop_level);
                    check_field("stop_valid", 32'(got.stop_valid), 32'(want.stop_valid));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int   sent;
        int   series_len;
        logic last;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_SHORT_MODE;
        i_cfg_wdata       = '0;
        bar_if.valid      = 1'b0;
        bar_if.low_price  = '0;
        bar_if.high_price = '0;
        bar_if.last_bar   = 1'b0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            low_hist[k]  = '0;
            high_hist[k] = '0;
        end
        // hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CFG: begin
                    settle();
                    write_reg(directed_rows[i].idx, directed_rows[i].data);
                end
                ROW_BAR_TYPED: feed_bar(directed_rows[i].bar, 1'b1, directed_rows[i].lvl);
                default:       feed_bar(directed_rows[i].bar, 1'b0, LVL_NONE);
            endcase
        end

        // random series under several register settings
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0:       write_all(7'h00, 7'd64, 7'd64, 7'd64);
                1:       write_all(7'h01, 7'd1, 7'd0, 7'd127);
                2:       write_all(7'h7F, 7'd64, 7'd20, 7'd3);
                default: write_all(7'($urandom_range(0, 127)), pick_window(), pick_window(),
                                   pick_window());
            endcase
            sent = 0;
            while (sent < BARS_PER_PHASE) begin
                series_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                         : $urandom_range(20, 90);
                for (int k = 0; k < series_len && sent < BARS_PER_PHASE; k++) begin
                    // an early last bar now and then breaks a series short
                    last = (k == series_len - 1) || ($urandom_range(0, 63) == 0);
                    feed_bar(random_bar(last), 1'b0, LVL_NONE);
                    sent++;
                end
            end
        end

        // drain and let the block come to rest
        settle();
        repeat (HIST_DEPTH + 4) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
